// ===== hdl/fdc_pkg.sv =====
// Shared types and constants for the floppy controller soft-switch block.
package fdc_pkg;

    localparam int TRACK_BYTES_DEF = 6656;
    localparam int TRACK_COUNT_DEF = 35;
    localparam int RESET_TRACK     = 20;
    localparam int TRACK_W         = 6;
    localparam int IMG_ADDR_W      = 18;

    localparam logic [7:0] RD_IDLE  = 8'hff;
    localparam logic [7:0] SENSE_WP = 8'h80;
    localparam logic [7:0] SENSE_RW = 8'h00;

    // request commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    // configuration register indexes
    localparam logic CFG_WRITE_PROTECT = 1'b0;
    localparam logic CFG_DISK_PRESENT  = 1'b1;

    // soft-switch addresses above the stepper phases
    localparam logic [3:0] SW_MOTOR_OFF = 4'h8;
    localparam logic [3:0] SW_MOTOR_ON  = 4'h9;
    localparam logic [3:0] SW_DRV0      = 4'ha;
    localparam logic [3:0] SW_DRV1      = 4'hb;
    localparam logic [3:0] SW_Q6L       = 4'hc;
    localparam logic [3:0] SW_Q6H       = 4'hd;
    localparam logic [3:0] SW_Q7L       = 4'he;
    localparam logic [3:0] SW_Q7H       = 4'hf;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [3:0]            reg_addr;
        logic [7:0]            write_data;
        logic [IMG_ADDR_W-1:0] image_addr;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         read_data;
        logic               spindle_on;
        logic [TRACK_W-1:0] head_track;
        logic               image_modified;
    } t_out_item;

endpackage

// ===== hdl/fdc_ram.sv =====
// Generic single-port RAM with registered read data.
module fdc_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
    ) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/floppy_controller_soft_switches.sv =====
// Floppy controller soft switches: decode, head stepper and nibble track store.
//
// Input channel (i_valid / o_stall, payload i_in): one request per bus access
// to the sixteen-byte switch window, or one image byte to load into the store.
// Output channel (o_valid / i_stall, payload o_out): exactly one result per
// request, in order, carrying read data plus motor, track and modified status.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_wdata) sets write protect and
// disk present; write it only while no request is in flight.
// An accepted request is registered in the first stage together with its store
// read, then moved to the result register. One request per cycle is sustained
// while the receiver does not stall; each request does at most one access to the
// single-port nibble store, whose registered read forms the first stage.
// When the receiver stalls, the result register holds, one more request may
// sit with its store read done, and then o_stall rises until space frees.
// Reset is synchronous: head at track 20, motor off, drive 0, latches clear.
// The nibble store has no reset; entries hold garbage until loaded.
module floppy_controller_soft_switches
    import fdc_pkg::*;
    #(
    parameter int TRACK_BYTES = TRACK_BYTES_DEF,
    parameter int TRACK_COUNT = TRACK_COUNT_DEF
    ) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic      i_cfg_wdata
);

    localparam int STORE_SIZE = TRACK_BYTES * TRACK_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int OFF_W      = $clog2(TRACK_BYTES);
    localparam int IDX_W      = (TRACK_W + OFF_W > IMG_ADDR_W) ? TRACK_W + OFF_W : IMG_ADDR_W;

    typedef struct packed {
        logic      nib;
        logic      in_range;
        t_out_item stat;
    } t_s1;

    logic               r_wp;
    logic               r_disk;
    logic [1:0]         r_phase,    n_phase;
    logic [TRACK_W-1:0] r_track,    n_track;
    logic               r_motor,    n_motor;
    logic               r_drive,    n_drive;
    logic [OFF_W-1:0]   r_offset,   n_offset;
    logic               r_q6,       n_q6;
    logic               r_q7,       n_q7;
    logic [7:0]         r_latch,    n_latch;
    logic               r_modified, n_modified;

    logic      r_s1_valid;
    t_s1       r_s1, n_s1;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item s1_out;

    logic               in_acc;
    logic               s1_adv;
    logic               head_ready;
    logic [OFF_W-1:0]   offset_inc;
    logic [IDX_W-1:0]   head_idx;
    logic               head_in;
    logic [IDX_W-1:0]   img_idx;
    logic [TRACK_W:0]   track_up;
    logic [1:0]         p;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    assign head_ready = r_disk && r_motor && !r_drive;
    assign offset_inc = ((OFF_W+1)'(r_offset) + (OFF_W+1)'(1) >= (OFF_W+1)'(TRACK_BYTES))
                      ? '0 : r_offset + OFF_W'(1);
    // Q6L never moves the head, so the registered track addresses the nibble
    assign head_idx = IDX_W'(r_track) * IDX_W'(TRACK_BYTES) + IDX_W'(offset_inc);
    assign head_in  = head_idx < IDX_W'(STORE_SIZE);
    assign img_idx  = IDX_W'(i_in.image_addr);
    assign track_up = (TRACK_W+1)'(r_track) + (TRACK_W+1)'(1);
    assign p        = i_in.reg_addr[2:1];

    always_comb begin
        n_phase    = r_phase;
        n_track    = r_track;
        n_motor    = r_motor;
        n_drive    = r_drive;
        n_offset   = r_offset;
        n_q6       = r_q6;
        n_q7       = r_q7;
        n_latch    = r_latch;
        n_modified = r_modified;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = head_idx[ADDR_W-1:0];
        ram_wdata  = r_latch;
        n_s1.nib      = 1'b0;
        n_s1.in_range = head_in;
        n_s1.stat.read_data = RD_IDLE;

        if (in_acc && (i_in.cmd == CMD_READ || i_in.cmd == CMD_WRITE)) begin
            if (!i_in.reg_addr[3]) begin
                if (i_in.reg_addr[0]) begin
                    if (p == r_phase + 2'd1) begin
                        n_phase = p;
                        if (!p[0]) begin
                            n_track = (track_up >= (TRACK_W+1)'(TRACK_COUNT))
                                    ? TRACK_W'(TRACK_COUNT - 1) : track_up[TRACK_W-1:0];
                        end
                    end else if (p == r_phase - 2'd1) begin
                        n_phase = p;
                        if (!p[0] && r_track != '0) begin
                            n_track = r_track - TRACK_W'(1);
                        end
                    end
                end
            end else begin
                unique case (i_in.reg_addr)
                    SW_MOTOR_OFF: n_motor = 1'b0;
                    SW_MOTOR_ON:  n_motor = 1'b1;
                    SW_DRV0:      n_drive = 1'b0;
                    SW_DRV1:      n_drive = 1'b1;
                    SW_Q6L: begin
                        n_q6 = 1'b0;
                        if (head_ready) begin
                            n_offset = offset_inc;
                            if (r_q7 && !r_wp) begin
                                n_modified = 1'b1;
                                ram_we     = head_in;
                            end
                            if (i_in.cmd == CMD_READ && !r_q7) begin
                                n_s1.nib = 1'b1;
                                ram_re   = head_in;
                            end
                        end
                    end
                    SW_Q6H: begin
                        n_q6 = 1'b1;
                        if (i_in.cmd == CMD_WRITE) begin
                            n_latch = i_in.write_data;
                        end
                    end
                    SW_Q7L: begin
                        n_q7 = 1'b0;
                        if (i_in.cmd == CMD_READ && r_q6) begin
                            n_s1.stat.read_data = r_wp ? SENSE_WP : SENSE_RW;
                        end
                    end
                    default: n_q7 = 1'b1;
                endcase
            end
        end else if (in_acc && i_in.cmd == CMD_LOAD) begin
            if (img_idx < IDX_W'(STORE_SIZE)) begin
                ram_we    = 1'b1;
                ram_addr  = img_idx[ADDR_W-1:0];
                ram_wdata = i_in.write_data;
            end
        end

        n_s1.stat.spindle_on     = n_motor;
        n_s1.stat.head_track     = n_track;
        n_s1.stat.image_modified = n_modified;
    end

    fdc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= 1'b0;
            r_disk      <= 1'b0;
            r_phase     <= '0;
            r_track     <= TRACK_W'(RESET_TRACK);
            r_motor     <= 1'b0;
            r_drive     <= 1'b0;
            r_offset    <= '0;
            r_q6        <= 1'b0;
            r_q7        <= 1'b0;
            r_latch     <= '0;
            r_modified  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WRITE_PROTECT) begin
                    r_wp <= i_cfg_wdata;
                end
                if (i_cfg_idx == CFG_DISK_PRESENT) begin
                    r_disk <= i_cfg_wdata;
                end
            end
            r_phase    <= n_phase;
            r_track    <= n_track;
            r_motor    <= n_motor;
            r_drive    <= n_drive;
            r_offset   <= n_offset;
            r_q6       <= n_q6;
            r_q7       <= n_q7;
            r_latch    <= n_latch;
            r_modified <= n_modified;
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // nibble reads take the store data, outside the store they read as zero
    always_comb begin
        s1_out = r_s1.stat;
        if (r_s1.nib) begin
            s1_out.read_data = r_s1.in_range ? ram_rdata : 8'h00;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv && r_s1_valid) begin
            r_out <= s1_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_one_port_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store read and write in the same cycle");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (OFF_W+1)'(r_offset) < (OFF_W+1)'(TRACK_BYTES))
        else $error("byte offset past end of track");

    a_track_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_track == TRACK_W'(RESET_TRACK) ||
        (TRACK_W+1)'(r_track) < (TRACK_W+1)'(TRACK_COUNT))
        else $error("head track out of range");

    a_modified_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_modified |=> r_modified)
        else $error("modified flag cleared");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_out_valid)
        else $error("request lost between store read and result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Floppy soft-switch block: directed request table, then random requests checked by a predictor.
module tb_top;
    import fdc_pkg::*;

    localparam int TRK_BYTES   = TRACK_BYTES_DEF;
    localparam int TRK_COUNT   = TRACK_COUNT_DEF;
    localparam int STORE_BYTES = TRK_BYTES * TRK_COUNT;

    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_valid     = 1'b0;
    logic      o_stall;
    t_in_item  i_in        = '0;
    logic      o_valid;
    logic      i_stall     = 1'b0;
    t_out_item o_out;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_idx   = CFG_WRITE_PROTECT;
    logic      i_cfg_wdata = 1'b0;

    floppy_controller_soft_switches uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // drive state as the block should see it
    logic        wp_cfg      = 1'b0;
    logic        present_cfg = 1'b0;
    logic [1:0]  step_phase  = 2'd0;
    logic [5:0]  head_trk    = 6'(RESET_TRACK);
    logic        motor       = 1'b0;
    logic        drive1      = 1'b0;
    logic [12:0] rot_off     = '0;
    logic        q6          = 1'b0;
    logic        q7          = 1'b0;
    logic [7:0]  latch       = '0;
    logic        modified    = 1'b0;
    logic [7:0]  nibbles [int unsigned];

    t_out_item status_q [$];
    t_plan_row plan [$];
    int        errors        = 0;
    int        send_idle_pct = 19;
    int        recv_idle_pct = 72;
    int        hold_reqs     = 0;
    int        seek_left     = 0;
    logic      seek_in       = 1'b0;

    function automatic logic head_ready();
        return present_cfg && motor && !drive1;
    endfunction

    function automatic int unsigned next_off();
        return (rot_off == TRK_BYTES - 1) ? 0 : rot_off + 1;
    endfunction

    function automatic int unsigned head_idx();
        return head_trk * TRK_BYTES + rot_off;
    endfunction

    function automatic void flip_switch(logic [3:0] a);
        logic [1:0]  p;
        int unsigned idx;
        p = a[2:1];
        if (!a[3]) begin
            if (a[0]) begin
                if (p == step_phase + 2'd1) begin
                    step_phase = p;
                    if (!p[0])
                        head_trk = 6'((head_trk + 1 >= TRK_COUNT) ? TRK_COUNT - 1
                                                                  : head_trk + 1);
                end else if (p == step_phase - 2'd1) begin
                    step_phase = p;
                    if (!p[0] && head_trk > 0)
                        head_trk = head_trk - 6'd1;
                end
            end
        end else begin
            case (a)
                SW_MOTOR_OFF: motor = 1'b0;
                SW_MOTOR_ON:  motor = 1'b1;
                SW_DRV0:      drive1 = 1'b0;
                SW_DRV1:      drive1 = 1'b1;
                SW_Q6L: begin
                    q6 = 1'b0;
                    if (head_ready()) begin
                        rot_off = 13'(next_off());
                        if (q7 && !wp_cfg) begin
                            idx = head_idx();
                            if (idx < STORE_BYTES)
                                nibbles[idx] = latch;
                            modified = 1'b1;
                        end
                    end
                end
                SW_Q6H:       q6 = 1'b1;
                SW_Q7L:       q7 = 1'b0;
                default:      q7 = 1'b1;
            endcase
        end
    endfunction

    function automatic t_out_item predict_status(t_in_item req);
        t_out_item   r;
        int unsigned idx;
        r.read_data = RD_IDLE;
        case (req.cmd)
            CMD_READ: begin
                flip_switch(req.reg_addr);
                if (req.reg_addr == SW_Q6L && head_ready() && !q7) begin
                    idx = head_idx();
                    r.read_data = (idx < STORE_BYTES && nibbles.exists(idx)) ? nibbles[idx] : 8'h00;
                end else if (req.reg_addr == SW_Q7L && q6) begin
                    r.read_data = wp_cfg ? SENSE_WP : SENSE_RW;
                end
            end
            CMD_WRITE: begin
                flip_switch(req.reg_addr);
                if (req.reg_addr == SW_Q6H)
                    latch = req.write_data;
            end
            CMD_LOAD: begin
                if (req.image_addr < STORE_BYTES)
                    nibbles[req.image_addr] = req.write_data;
            end
            default: ;
        endcase
        r.spindle_on     = motor;
        r.head_track     = head_trk;
        r.image_modified = modified;
        return r;
    endfunction

    // Mostly head seeks and nibble reads; reads of unset nibbles become loads of that spot.
    function automatic t_in_item rand_request();
        t_in_item    q;
        int unsigned pick;
        int unsigned idx;
        q.cmd        = $urandom_range(1, 0) ? CMD_READ : CMD_WRITE;
        q.reg_addr   = 4'($urandom_range(15, 0));
        q.write_data = 8'($urandom_range(255, 0));
        q.image_addr = 18'($urandom_range(STORE_BYTES - 1, 0));
        pick = $urandom_range(99, 0);
        if (pick < 30) begin
            if (seek_left == 0) begin
                seek_left = $urandom_range(90, 60);
                seek_in   = !seek_in;
            end
            seek_left--;
            q.reg_addr = {1'b0, seek_in ? step_phase + 2'd1 : step_phase - 2'd1, 1'b1};
        end else if (pick < 52) begin
            q.cmd      = ($urandom_range(3, 0) != 0) ? CMD_READ : CMD_WRITE;
            q.reg_addr = SW_Q6L;
        end else if (pick < 64) begin
            q.reg_addr = 4'($urandom_range(15, 13));
        end else if (pick < 70) begin
            q.reg_addr = ($urandom_range(3, 0) == 0) ? SW_MOTOR_OFF : SW_MOTOR_ON;
        end else if (pick < 74) begin
            q.reg_addr = ($urandom_range(4, 0) < 3) ? SW_DRV0 : SW_DRV1;
        end else if (pick < 88) begin
            q.cmd = CMD_LOAD;
            case ($urandom_range(2, 0))
                0:       q.image_addr = 18'(head_trk * TRK_BYTES + next_off());
                1:       ;
                default: q.image_addr = 18'($urandom_range(2**IMG_ADDR_W - 1, 0));
            endcase
        end else begin
            q = t_in_item'($urandom());
        end
        if (q.cmd == CMD_READ && q.reg_addr == SW_Q6L && head_ready() && !q7) begin
            idx = head_trk * TRK_BYTES + next_off();
            if (!nibbles.exists(idx)) begin
                q.cmd        = CMD_LOAD;
                q.image_addr = 18'(idx);
            end
        end
        return q;
    endfunction

    function automatic t_plan_row row(logic [1:0] c, logic [3:0] a, logic [7:0] d,
                                      logic [17:0] ia, logic [7:0] rd, logic m,
                                      logic [5:0] trk, logic md);
        t_plan_row pr;
        pr.req   = '{cmd: c, reg_addr: a, write_data: d, image_addr: ia};
        pr.typed = 1'b1;
        pr.want  = '{read_data: rd, spindle_on: m, head_track: trk, image_modified: md};
        return pr;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(t_in_item req, logic typed, t_out_item want);
        t_out_item got;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= req;
        do @(posedge i_clk); while (o_stall);
        got = predict_status(req);
        status_q.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (status_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_disk(logic protect, logic present);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_WRITE_PROTECT;
        i_cfg_wdata <= protect;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_DISK_PRESENT;
        i_cfg_wdata <= present;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        wp_cfg      = protect;
        present_cfg = present;
    endtask

    task automatic flag(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    t_out_item due;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_q.size() == 0) begin
                flag($sformatf("%0t: unexpected result rd=%h motor=%b track=%0d mod=%b",
                               $realtime, o_out.read_data, o_out.spindle_on,
                               o_out.head_track, o_out.image_modified));
            end else begin
                due = status_q.pop_front();
                if (o_out.read_data !== due.read_data || o_out.spindle_on !== due.spindle_on ||
                    o_out.head_track !== due.head_track ||
                    o_out.image_modified !== due.image_modified)
                    flag($sformatf({"%0t: mismatch exp rd=%h motor=%b track=%0d mod=%b",
                                    " got rd=%h motor=%b track=%0d mod=%b"}, $realtime,
                                   due.read_data, due.spindle_on, due.head_track,
                                   due.image_modified, o_out.read_data, o_out.spindle_on,
                                   o_out.head_track, o_out.image_modified));
            end
        end
    end

    logic cfg_wp [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic cfg_dp [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    initial begin
        // stepping: odd addresses only, adjacent phases move on even phases
        plan.push_back(row(CMD_READ,  SW_MOTOR_OFF, 8'h00, 18'd0, 8'hff, 1'b0, 6'd20, 1'b0));
        plan.push_back(row(CMD_READ,  4'h3, 8'h00, 18'd0, 8'hff, 1'b0, 6'd20, 1'b0));
        plan.push_back(row(CMD_WRITE, 4'h5, 8'h00, 18'd0, 8'hff, 1'b0, 6'd21, 1'b0));
        plan.push_back(row(CMD_READ,  4'h4, 8'h00, 18'd0, 8'hff, 1'b0, 6'd21, 1'b0));
        plan.push_back(row(CMD_READ,  4'h1, 8'h00, 18'd0, 8'hff, 1'b0, 6'd21, 1'b0));
        plan.push_back(row(CMD_READ,  4'h3, 8'h00, 18'd0, 8'hff, 1'b0, 6'd21, 1'b0));
        plan.push_back(row(CMD_READ,  4'h1, 8'h00, 18'd0, 8'hff, 1'b0, 6'd20, 1'b0));
        plan.push_back(row(CMD_READ,  4'h7, 8'h00, 18'd0, 8'hff, 1'b0, 6'd20, 1'b0));
        plan.push_back(row(CMD_READ,  4'h1, 8'h00, 18'd0, 8'hff, 1'b0, 6'd21, 1'b0));
        // motor on, load the next nibble under the head and read it back
        plan.push_back(row(CMD_WRITE, SW_MOTOR_ON, 8'hff, 18'd0, 8'hff, 1'b1, 6'd21, 1'b0));
        plan.push_back(row(CMD_LOAD,  4'h0, 8'ha5, 18'd139777, 8'hff, 1'b1, 6'd21, 1'b0));
        plan.push_back(row(CMD_READ,  SW_Q6L, 8'h00, 18'd0, 8'ha5, 1'b1, 6'd21, 1'b0));
        // latch a byte and write it to disk
        plan.push_back(row(CMD_WRITE, SW_Q6H, 8'h5a, 18'd0, 8'hff, 1'b1, 6'd21, 1'b0));
        plan.push_back(row(CMD_WRITE, SW_Q7H, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b0));
        plan.push_back(row(CMD_READ,  SW_Q6L, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_READ,  SW_Q7L, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_WRITE, SW_Q6H, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_READ,  SW_Q7L, 8'h00, 18'd0, SENSE_RW, 1'b1, 6'd21, 1'b1));
        // unused command, loads past the store and at both ends
        plan.push_back(row(2'd3, SW_Q7H, 8'hff, 18'h3ffff, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_LOAD, 4'hf, 8'hff, 18'h3ffff, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_LOAD, 4'h0, 8'h00, 18'd232959, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_LOAD, 4'h0, 8'hff, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));
        // second drive: strobe does nothing
        plan.push_back(row(CMD_WRITE, SW_DRV1, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_READ,  SW_Q6L, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));
        plan.push_back(row(CMD_WRITE, SW_DRV0, 8'h00, 18'd0, 8'hff, 1'b1, 6'd21, 1'b1));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_disk(1'b0, 1'b1);
        foreach (plan[k])
            offer(plan[k].req, plan[k].typed, plan[k].want);

        for (int blk = 0; blk < 6; blk++) begin
            drain();
            if (blk == 2) begin
                send_idle_pct = 72;
                recv_idle_pct = 19;
            end else if (blk == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_disk(cfg_wp[blk], cfg_dp[blk]);
            if (blk == 1 || blk == 4)
                hold_reqs++;
            repeat (155)
                offer(rand_request(), 1'b0, '0);
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #200000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
